>>> sv/sstd_pkg.sv
// shared constants and types for the slit-scan time displacement block
package sstd_pkg;

  localparam int MAX_BANDS_DEF  = 64;
  localparam int MAX_ROWS_DEF   = 256;
  localparam int MAX_COLS_DEF   = 256;
  localparam int PIXEL_BITS_DEF = 24;

  localparam int BAND_COUNT_W = 7;
  localparam int FRAME_ROWS_W = 9;
  localparam int CFG_DATA_W   = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int DIV_CNT_W    = $clog2(FRAME_ROWS_W + 1);

  localparam logic [BAND_COUNT_W-1:0] BAND_COUNT_RST = 7'd50;
  localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST = 9'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_COUNT = 1'b0,
    REG_FRAME_ROWS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> sv/sstd_if.sv
// stream interfaces for the pixel input and the displaced pixel output
interface sstd_in_if
  import sstd_pkg::*;
#(
  parameter int PIX_W = PIXEL_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             line_end;
  logic             frame_end;

  modport source (output valid, output pixel_in, output line_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_in, input line_end, input frame_end,
                  output ready);
endinterface

interface sstd_out_if
  import sstd_pkg::*;
#(
  parameter int PIX_W = PIXEL_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             out_line_end;
  logic             out_frame_end;

  modport source (output valid, output pixel_out, output out_line_end,
                  output out_frame_end, input ready);
  modport sink   (input valid, input pixel_out, input out_line_end,
                  input out_frame_end, output ready);
endinterface

>>> sv/sstd_div.sv
// bit-serial restoring divider for rows per band
module sstd_div
  import sstd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [FRAME_ROWS_W-1:0] dividend_i,
  input  logic [BAND_COUNT_W-1:0] divisor_i,
  output logic [FRAME_ROWS_W-1:0] quot_o,
  output div_status_t             status_o
);

  logic [DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [FRAME_ROWS_W-1:0] quo_q, quo_d;
  logic [BAND_COUNT_W-1:0] rem_q, rem_d;
  logic [BAND_COUNT_W-1:0] dvs_q, dvs_d;
  logic [BAND_COUNT_W:0]   rem_sh;
  logic [BAND_COUNT_W:0]   rem_sub;
  logic                    ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[FRAME_ROWS_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      cnt_d  = DIV_CNT_W'(FRAME_ROWS_W);
      busy_d = 1'b1;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // one quotient bit per cycle
      quo_d = {quo_q[FRAME_ROWS_W-2:0], ge};
      rem_d = ge ? rem_sub[BAND_COUNT_W-1:0] : rem_sh[BAND_COUNT_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quot_o        = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

>>> sv/sstd_store.sv
// frame history and first-frame memories with read registers and forwarding
module sstd_store
  import sstd_pkg::*;
#(
  parameter int          PIXEL_BITS = PIXEL_BITS_DEF,
  parameter longint      HIST_DEPTH = 64'(MAX_BANDS_DEF) * MAX_ROWS_DEF * MAX_COLS_DEF,
  parameter int          FRAME_PIX  = MAX_ROWS_DEF * MAX_COLS_DEF,
  parameter int          HIST_AW    = $clog2(HIST_DEPTH),
  parameter int          ADDR_W     = $clog2(FRAME_PIX)
) (
  input  logic                  clk_i,
  input  logic                  hist_we_i,
  input  logic [HIST_AW-1:0]    hist_waddr_i,
  input  logic                  hist_re_i,
  input  logic [HIST_AW-1:0]    hist_raddr_i,
  input  logic                  first_we_i,
  input  logic                  first_re_i,
  input  logic [ADDR_W-1:0]     first_addr_i,
  input  logic [PIXEL_BITS-1:0] wdata_i,
  input  logic                  rd_en_i,
  input  logic                  sel_first_i,
  input  logic                  fwd_i,
  output logic [PIXEL_BITS-1:0] rdata_o
);

  logic [PIXEL_BITS-1:0] hist_mem  [HIST_DEPTH];
  logic [PIXEL_BITS-1:0] first_mem [FRAME_PIX];
  logic [PIXEL_BITS-1:0] hist_rd_q;
  logic [PIXEL_BITS-1:0] first_rd_q;
  logic [PIXEL_BITS-1:0] fwd_pix_q;
  logic                  sel_first_q;
  logic                  fwd_q;

  always_ff @(posedge clk_i) begin
    if (hist_re_i) begin
      hist_rd_q <= hist_mem[hist_raddr_i];
    end
    if (hist_we_i) begin
      hist_mem[hist_waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (first_re_i) begin
      first_rd_q <= first_mem[first_addr_i];
    end
    if (first_we_i) begin
      first_mem[first_addr_i] <= wdata_i;
    end
  end

  // read and write of the same entry in one cycle: the new pixel wins
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sel_first_q <= sel_first_i;
      fwd_q       <= fwd_i;
      fwd_pix_q   <= wdata_i;
    end
  end

  assign rdata_o = fwd_q ? fwd_pix_q : (sel_first_q ? first_rd_q : hist_rd_q);

endmodule

>>> sv/slit_scan_time_displacement.sv
// slit-scan time displacement: top level with raster counters and output stage
//
//  port      | dir | transaction payload
//  ----------+-----+------------------------------------------------
//  in_i      | in  | pixel_in, line_end, frame_end
//  out_o     | out | pixel_out, out_line_end, out_frame_end
//  cfg_*_i   | in  | register index and write data, no handshake
//
// one pixel per clock while neither a register write nor a stalled output holds the
// input; a pixel is read into the read registers at the edge that takes it, then moves to the output register.
// the two frame memories have no reset and are not cleared.
// after a register write the input stalls while the 9-step serial divider
// derives rows per band.
// a stalled output holds the read stage; in_i keeps taking a transaction
// while a result waits as long as the read stage is free.
module slit_scan_time_displacement
  import sstd_pkg::*;
#(
  parameter int MAX_BANDS  = MAX_BANDS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sstd_in_if.sink               in_i,
  sstd_out_if.source            out_o
);

  localparam int     SLOT_W     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int     ROW_W      = $clog2(MAX_ROWS);
  localparam int     COL_W      = $clog2(MAX_COLS);
  localparam int     FRAME_PIX  = MAX_ROWS * MAX_COLS;
  localparam int     ADDR_W     = $clog2(FRAME_PIX);
  localparam longint HIST_DEPTH = 64'(MAX_BANDS) * 64'(FRAME_PIX);
  localparam int     HIST_AW    = $clog2(HIST_DEPTH);
  localparam int     RST_N      = (int'(BAND_COUNT_RST) > MAX_BANDS) ? MAX_BANDS
                                                                      : int'(BAND_COUNT_RST);
  localparam int     RST_FR     = (int'(FRAME_ROWS_RST) > MAX_ROWS) ? MAX_ROWS
                                                                      : int'(FRAME_ROWS_RST);
  localparam int     RST_RPB    = RST_FR / RST_N;

  // registers and counters
  logic [BAND_COUNT_W-1:0] bc_q;
  logic [FRAME_ROWS_W-1:0] fr_q;
  logic [FRAME_ROWS_W-1:0] rpb_q;
  logic                    cfg_start_q;
  logic [COL_W-1:0]        col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [BAND_COUNT_W-1:0] band_q, band_d;
  logic [FRAME_ROWS_W-1:0] rib_q, rib_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [BAND_COUNT_W-1:0] seen_q, seen_d;

  // pipeline control
  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_le_q, s1_fe_q;
  logic                    out_valid_q, out_valid_d;
  logic [PIXEL_BITS-1:0]   out_pix_q;
  logic                    out_le_q, out_fe_q;
  logic                    adv1;
  logic                    accept;
  logic                    busy;

  // datapath
  logic [BAND_COUNT_W-1:0] n_eff;
  logic [BAND_COUNT_W-1:0] seen;
  logic [FRAME_ROWS_W-1:0] fr_clip;
  logic [ADDR_W-1:0]       pix_addr;
  logic [BAND_COUNT_W-1:0] lag;
  logic [SLOT_W:0]         src_diff;
  logic [SLOT_W-1:0]       src_slot;
  logic                    full;
  logic                    use_first;
  logic                    fwd;
  logic [HIST_AW-1:0]      hist_waddr;
  logic [HIST_AW-1:0]      hist_raddr;
  logic [PIXEL_BITS-1:0]   store_rdata;
  logic [FRAME_ROWS_W-1:0] rib_inc;
  logic [BAND_COUNT_W:0]   seen_inc;
  logic [FRAME_ROWS_W-1:0] div_quot;
  div_status_t             div_st;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q        <= BAND_COUNT_RST;
      fr_q        <= FRAME_ROWS_RST;
      cfg_start_q <= 1'b0;
    end else begin
      cfg_start_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BAND_COUNT: bc_q <= cfg_data_i[BAND_COUNT_W-1:0];
          REG_FRAME_ROWS: fr_q <= cfg_data_i[FRAME_ROWS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (bc_q == '0) begin
      n_eff = BAND_COUNT_W'(1);
    end else if (32'(bc_q) > 32'(MAX_BANDS)) begin
      n_eff = BAND_COUNT_W'(MAX_BANDS);
    end else begin
      n_eff = bc_q;
    end
    fr_clip = (32'(fr_q) > 32'(MAX_ROWS)) ? FRAME_ROWS_W'(MAX_ROWS) : fr_q;
  end

  sstd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_start_q),
    .dividend_i (fr_clip),
    .divisor_i  (n_eff),
    .quot_o     (div_quot),
    .status_o   (div_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpb_q <= FRAME_ROWS_W'(RST_RPB);
    end else if (div_st.done) begin
      rpb_q <= div_quot;
    end
  end

  // handshake
  assign busy        = cfg_we_i || cfg_start_q || div_st.busy || div_st.done;
  assign adv1        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !busy && (!s1_valid_q || adv1);
  assign accept      = in_i.valid && in_i.ready;
  assign s1_valid_d  = accept || (s1_valid_q && !adv1);
  assign out_valid_d = adv1 || (out_valid_q && !out_o.ready);

  // source frame selection
  always_comb begin
    seen     = (seen_q < n_eff) ? seen_q : n_eff;
    pix_addr = ADDR_W'(32'(row_q) * MAX_COLS + 32'(col_q));
    full     = ({1'b0, seen} + 1'b1) >= {1'b0, n_eff};
    lag      = n_eff - 1'b1 - band_q;
    src_diff = {1'b0, slot_q} - {1'b0, SLOT_W'(lag)};
    if (src_diff[SLOT_W]) begin
      src_diff = src_diff + (SLOT_W + 1)'(MAX_BANDS);
    end
    use_first = 1'b0;
    src_slot  = src_diff[SLOT_W-1:0];
    if (rpb_q == '0 || band_q >= n_eff) begin
      use_first = 1'b1;
    end else if (full) begin
      src_slot = src_diff[SLOT_W-1:0];
    end else if (band_q <= seen) begin
      src_slot = SLOT_W'(band_q);
    end else begin
      use_first = 1'b1;
    end
    fwd        = use_first ? (seen == '0) : (src_slot == slot_q);
    hist_waddr = HIST_AW'(64'(slot_q) * 64'(FRAME_PIX) + 64'(pix_addr));
    hist_raddr = HIST_AW'(64'(src_slot) * 64'(FRAME_PIX) + 64'(pix_addr));
  end

  sstd_store #(
    .PIXEL_BITS (PIXEL_BITS),
    .HIST_DEPTH (HIST_DEPTH),
    .FRAME_PIX  (FRAME_PIX),
    .HIST_AW    (HIST_AW),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk_i        (clk_i),
    .hist_we_i    (accept),
    .hist_waddr_i (hist_waddr),
    .hist_re_i    (accept && !use_first),
    .hist_raddr_i (hist_raddr),
    .first_we_i   (accept && (seen == '0)),
    .first_re_i   (accept && use_first),
    .first_addr_i (pix_addr),
    .wdata_i      (in_i.pixel_in),
    .rd_en_i      (accept),
    .sel_first_i  (use_first),
    .fwd_i        (fwd),
    .rdata_o      (store_rdata)
  );

  // raster position and frame ring bookkeeping
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    band_d   = band_q;
    rib_d    = rib_q;
    slot_d   = slot_q;
    seen_d   = seen_q;
    rib_inc  = rib_q + 1'b1;
    seen_inc = {1'b0, seen} + 1'b1;
    if (accept) begin
      if (in_i.frame_end) begin
        col_d  = '0;
        row_d  = '0;
        band_d = '0;
        rib_d  = '0;
        slot_d = (slot_q == SLOT_W'(MAX_BANDS - 1)) ? '0 : slot_q + 1'b1;
        seen_d = (seen_inc < {1'b0, n_eff}) ? seen_inc[BAND_COUNT_W-1:0] : n_eff;
      end else if (in_i.line_end) begin
        col_d = '0;
        row_d = (row_q == ROW_W'(MAX_ROWS - 1)) ? '0 : row_q + 1'b1;
        if (band_q < n_eff) begin
          if (rib_inc >= rpb_q) begin
            rib_d  = '0;
            band_d = band_q + 1'b1;
          end else begin
            rib_d = rib_inc;
          end
        end
      end else begin
        col_d = (col_q == COL_W'(MAX_COLS - 1)) ? '0 : col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      band_q      <= '0;
      rib_q       <= '0;
      slot_q      <= '0;
      seen_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      band_q      <= band_d;
      rib_q       <= rib_d;
      slot_q      <= slot_d;
      seen_q      <= seen_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_le_q <= in_i.line_end;
      s1_fe_q <= in_i.frame_end;
    end
    if (adv1) begin
      out_pix_q <= store_rdata;
      out_le_q  <= s1_le_q;
      out_fe_q  <= s1_fe_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_out     = out_pix_q;
  assign out_o.out_line_end  = out_le_q;
  assign out_o.out_frame_end = out_fe_q;

endmodule

>>> sim/tb_slit_scan_time_displacement.sv
// self-checking testbench for slit_scan_time_displacement with predictor and random stalls
module tb_slit_scan_time_displacement;
  import sstd_pkg::*;

  localparam int FRAME_PIXELS = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int RUN_LIMIT    = 400_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 100;
  localparam logic [23:0] CORNER_PIX [8] = '{24'h000000, 24'hffffff, 24'h800000, 24'h7fffff,
                                              24'h555555, 24'haaaaaa, 24'h000001, 24'hfffffe};

  typedef struct packed {
    logic [PIXEL_BITS_DEF-1:0] pixel;
    logic                      line_end;
    logic                      frame_end;
  } pixel_beat_t;

  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_EVERY_THIRD, RDY_COIN} ready_pattern_e;

  // tracks raster position and frame ring, predicts each displaced pixel
  class band_delay_tracker;
    bit [PIXEL_BITS_DEF-1:0] history_mem [int];
    bit [PIXEL_BITS_DEF-1:0] first_frame_mem [int];
    int band_count_reg, frame_rows_reg, rows_per_band;
    int newest_slot, frames_seen, row_cnt, col_cnt, band_cnt, row_in_band;
    pixel_beat_t expected_pixels[$];
    int mismatches;

    function int bands(int bc);
      if (bc == 0) return 1;
      if (bc > MAX_BANDS_DEF) return MAX_BANDS_DEF;
      return bc;
    endfunction

    function int band_rows(int bc, int fr);
      return (fr > MAX_ROWS_DEF ? MAX_ROWS_DEF : fr) / bands(bc);
    endfunction

    function new();
      band_count_reg = BAND_COUNT_RST;
      frame_rows_reg = FRAME_ROWS_RST;
      rows_per_band  = band_rows(band_count_reg, frame_rows_reg);
      newest_slot = 0;
      frames_seen = 0;
      row_cnt = 0;
      col_cnt = 0;
      band_cnt = 0;
      row_in_band = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_BAND_COUNT) begin
        band_count_reg = data[BAND_COUNT_W-1:0];
      end else begin
        frame_rows_reg = data[FRAME_ROWS_W-1:0];
      end
      rows_per_band = band_rows(band_count_reg, frame_rows_reg);
    endfunction

    // true when the older frame read at this position holds data
    function bit read_defined(int row, int col, int band, int n, int rpb);
      int seen, addr, src;
      seen = frames_seen < n ? frames_seen : n;
      addr = row * MAX_COLS_DEF + col;
      if (rpb == 0 || band >= n || (seen + 1 < n && band > seen)) begin
        return seen == 0 || first_frame_mem.exists(addr);
      end
      if (seen + 1 >= n) begin
        src = (newest_slot + MAX_BANDS_DEF - (n - 1 - band)) % MAX_BANDS_DEF;
      end else begin
        src = band;
      end
      return src == newest_slot || history_mem.exists(src * FRAME_PIXELS + addr);
    endfunction

    // position of the pixel after one with these flags (no frame end)
    function bit next_read_defined(bit line_end);
      int row, col, band, rib, n;
      row  = row_cnt;
      col  = col_cnt;
      band = band_cnt;
      rib  = row_in_band;
      n    = bands(band_count_reg);
      if (line_end) begin
        col = 0;
        row = (row + 1) % MAX_ROWS_DEF;
        if (band < n) begin
          rib++;
          if (rib >= rows_per_band) band++;
        end
      end else begin
        col = (col + 1) % MAX_COLS_DEF;
      end
      return read_defined(row, col, band, n, rows_per_band);
    endfunction

    function bit config_safe(int bc, int fr);
      return read_defined(row_cnt, col_cnt, band_cnt, bands(bc), band_rows(bc, fr));
    endfunction

    function void take_pixel(logic [PIXEL_BITS_DEF-1:0] pix, logic le, logic fe);
      int n, seen, addr, src;
      pixel_beat_t beat;
      n    = bands(band_count_reg);
      seen = frames_seen < n ? frames_seen : n;
      addr = row_cnt * MAX_COLS_DEF + col_cnt;
      history_mem[newest_slot * FRAME_PIXELS + addr] = pix;
      if (seen == 0) first_frame_mem[addr] = pix;
      if (rows_per_band == 0 || band_cnt >= n || (seen + 1 < n && band_cnt > seen)) begin
        beat.pixel = first_frame_mem[addr];
      end else begin
        if (seen + 1 >= n) begin
          src = (newest_slot + MAX_BANDS_DEF - (n - 1 - band_cnt)) % MAX_BANDS_DEF;
        end else begin
          src = band_cnt;
        end
        beat.pixel = history_mem[src * FRAME_PIXELS + addr];
      end
      beat.line_end  = le;
      beat.frame_end = fe;
      expected_pixels.insert(expected_pixels.size(), beat);

      if (fe) begin
        col_cnt = 0;
        row_cnt = 0;
        band_cnt = 0;
        row_in_band = 0;
        newest_slot = (newest_slot + 1) % MAX_BANDS_DEF;
        frames_seen = (seen + 1 < n) ? seen + 1 : n;
      end else if (le) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1) % MAX_ROWS_DEF;
        if (band_cnt < n) begin
          row_in_band++;
          if (row_in_band >= rows_per_band) begin
            row_in_band = 0;
            band_cnt++;
          end
        end
      end else begin
        col_cnt = (col_cnt + 1) % MAX_COLS_DEF;
      end
    endfunction

    function void check_pixel(logic [PIXEL_BITS_DEF-1:0] pix, logic le, logic fe);
      pixel_beat_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("output with nothing expected: pixel %h le %b fe %b", pix, le, fe);
        end
        return;
      end
      want = expected_pixels.pop_front();
      if (want.pixel !== pix || want.line_end !== le || want.frame_end !== fe) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected pixel %h le %b fe %b, got pixel %h le %b fe %b",
                   want.pixel, want.line_end, want.frame_end, pix, le, fe);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sstd_in_if  in_if ();
  sstd_out_if out_if ();

  slit_scan_time_displacement uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  band_delay_tracker tracker = new();

  bit gaps_on;
  bit hold_req;
  int burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hffffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // offers one pixel; ends the frame instead when the next read would hit unwritten memory
  task automatic send_pixel(input logic [23:0] pix, input logic le, input logic fe_in,
                            output bit ended);
    logic fe;
    fe = fe_in;
    if (!fe && !tracker.next_read_defined(le)) fe = 1'b1;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.pixel_in  <= pix;
    in_if.line_end  <= le;
    in_if.frame_end <= fe;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.take_pixel(pix, le, fe);
    ended = fe;
  endtask

  task automatic send_frame(input int rows, input int cols, input bit noisy, inout int budget);
    bit ended;
    logic le, fe;
    ended = 1'b0;
    for (int r = 0; r < rows && !ended && budget > 0; r++) begin
      for (int c = 0; c < cols && !ended && budget > 0; c++) begin
        le = (c == cols - 1);
        fe = le && (r == rows - 1);
        // broken raster: stray line and frame ends
        if (noisy && $urandom_range(0, 9) == 0) begin
          le = $urandom_range(0, 1);
          fe = ($urandom_range(0, 5) == 0);
        end
        send_pixel(rand_pixel(), le, fe, ended);
        budget--;
      end
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] bc, input logic [CFG_DATA_W-1:0] fr,
                           input int items, input int max_rows, input int max_cols,
                           input bit gaps, input bit hold);
    int budget;
    bit ended;
    drain();
    // close the frame first if the new setting would read unwritten memory
    if (!tracker.config_safe(int'(bc[BAND_COUNT_W-1:0]), int'(fr))) begin
      send_pixel(rand_pixel(), 1'b0, 1'b1, ended);
      drain();
    end
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BAND_COUNT;
    cfg_data_i <= bc;
    @(posedge clk_i);
    cfg_idx_i  <= REG_FRAME_ROWS;
    cfg_data_i <= fr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_reg(REG_BAND_COUNT, bc);
    tracker.write_reg(REG_FRAME_ROWS, fr);
    gaps_on    = gaps;
    burst_left = 0;
    if (hold) hold_req = 1'b1;
    budget = items;
    while (budget > 0) begin
      send_frame($urandom_range(1, max_rows), $urandom_range(1, max_cols), 1'b1, budget);
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      tracker.check_pixel(out_if.pixel_out, out_if.out_line_end, out_if.out_frame_end);
    end
  end

  // receiver: changing stall patterns plus one long hold-off on request
  initial begin
    ready_pattern_e pattern;
    int pattern_left, hold_left, tick;
    pattern = RDY_ALWAYS;
    pattern_left = 0;
    hold_left = 0;
    tick = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern = ready_pattern_e'($urandom_range(0, 3));
          pattern_left = $urandom_range(30, 150);
        end
        pattern_left--;
        case (pattern)
          RDY_ALWAYS:      out_if.ready <= 1'b1;
          RDY_MOSTLY:      out_if.ready <= ($urandom_range(0, 3) != 0);
          RDY_EVERY_THIRD: out_if.ready <= (tick % 3 != 0);
          default:         out_if.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("slit_scan_time_displacement regression: fail");
    $finish;
  end

  initial begin
    int budget;
    bit ended;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_BAND_COUNT;
    cfg_data_i         <= '0;
    in_if.valid        <= 1'b0;
    in_if.pixel_in     <= '0;
    in_if.line_end     <= 1'b0;
    in_if.frame_end    <= 1'b0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: first frame of 4 rows by 5 columns with extreme pixels
    for (int i = 0; i < 20; i++) begin
      send_pixel(i < 8 ? CORNER_PIX[i] : rand_pixel(), i % 5 == 4, i == 19, ended);
    end
    // frame end without line end, then a two-row frame
    send_pixel(rand_pixel(), 1'b0, 1'b1, ended);
    send_pixel(rand_pixel(), 1'b1, 1'b0, ended);
    send_pixel(rand_pixel(), 1'b0, 1'b1, ended);

    run_phase(9'd4, 9'd8, 30, 6, 5, 1'b1, 1'b0);
    // zero band count acts as one, zero rows gives no bands
    run_phase(9'd0, 9'd0, 15, 4, 5, 1'b1, 1'b0);
    // full ring of 64 frames, oversized frame rows
    run_phase(9'd64, 9'd511, 80, 1, 1, 1'b1, 1'b0);
    // fewer rows than bands
    run_phase(9'd2, 9'd1, 15, 4, 5, 1'b1, 1'b0);
    // band count above the ring size
    run_phase(9'd127, 9'd256, 20, 2, 3, 1'b1, 1'b0);
    // rows past the last band; receiver holds off while input keeps coming
    run_phase(9'd3, 9'd4, 40, 6, 4, 1'b0, 1'b1);
    // single band: row and column counters wrap past the store
    run_phase(9'd1, 9'd256, 0, 1, 1, 1'b1, 1'b0);
    budget = 600;
    send_frame(1, 258, 1'b0, budget);
    send_frame(258, 1, 1'b0, budget);
    // band count raised after saturation
    run_phase(9'd7, 9'd100, 20, 6, 6, 1'b1, 1'b0);
    repeat (3) begin
      run_phase({2'($urandom_range(0, 3)), 7'($urandom_range(1, 12))},
                9'($urandom_range(0, 511)), 10, 5, 5, 1'($urandom_range(0, 1)), 1'b0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("slit_scan_time_displacement regression: pass");
    end else begin
      $display("slit_scan_time_displacement regression: fail");
    end
    $finish;
  end

endmodule
